>>> design/cmta_pkg.sv
// ----------------------------------------------------------------------------
// cmta_pkg: shared types and sequence tables for the color markup translator
// Command codes passed from the front end to the back end, and the functions
// that give the length and the bytes of each expanded escape sequence.
// ----------------------------------------------------------------------------
package cmta_pkg;

    // ASCII bytes used in the emitted sequences
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_FOUR   = 8'h34;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_CARET  = 8'h5E;

    localparam int IDX_W = 4;

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_AMP,
        PFX_CARET
    } t_pfx;

    typedef enum logic [2:0] {
        K_TEXT,     // one byte passed through
        K_LIT,      // prefix character and the code byte, unchanged
        K_RST,      // plain reset
        K_FG,       // reset, then normal foreground
        K_FGB,      // reset, then bright foreground
        K_BG,       // normal background
        K_BGB,      // bright background
        K_EOM       // optional pending prefix, then closing reset
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        t_pfx       pfx;
        logic [7:0] data;   // text byte, or color digit 0..7
    } t_cmd;

    function automatic logic has_pfx(t_pfx p);
        return (p == PFX_AMP) || (p == PFX_CARET);
    endfunction

    function automatic logic [7:0] pfx_char(t_pfx p);
        return (p == PFX_CARET) ? CH_CARET : CH_AMP;
    endfunction

    function automatic logic [7:0] reset_byte(logic [1:0] j);
        logic [7:0] b;
        case (j)
            2'd0:    b = CH_ESC;
            2'd1:    b = CH_LBRACK;
            2'd2:    b = CH_ZERO;
            default: b = CH_M;
        endcase
        return b;
    endfunction

    function automatic logic [IDX_W-1:0] cmd_len(t_cmd cmd);
        logic [IDX_W-1:0] n;
        case (cmd.kind)
            K_TEXT:  n = IDX_W'(1);
            K_LIT:   n = IDX_W'(2);
            K_RST:   n = IDX_W'(4);
            K_FG:    n = IDX_W'(9);
            K_FGB:   n = IDX_W'(11);
            K_BG:    n = IDX_W'(5);
            K_BGB:   n = IDX_W'(6);
            K_EOM:   n = has_pfx(cmd.pfx) ? IDX_W'(5) : IDX_W'(4);
            default: n = IDX_W'(1);
        endcase
        return n;
    endfunction

    function automatic logic [7:0] cmd_byte(t_cmd cmd, logic [IDX_W-1:0] idx);
        logic [7:0]       dch;
        logic [IDX_W-1:0] j;
        logic [7:0]       b;
        dch = CH_ZERO + cmd.data;
        j   = idx - IDX_W'(1);
        b   = cmd.data;
        case (cmd.kind)
            K_TEXT: b = cmd.data;
            K_LIT:  b = (idx == '0) ? pfx_char(cmd.pfx) : cmd.data;
            K_RST:  b = reset_byte(idx[1:0]);
            K_FG: begin
                case (idx)
                    4'd0, 4'd1, 4'd2, 4'd3: b = reset_byte(idx[1:0]);
                    4'd4:    b = CH_ESC;
                    4'd5:    b = CH_LBRACK;
                    4'd6:    b = CH_THREE;
                    4'd7:    b = dch;
                    default: b = CH_M;
                endcase
            end
            K_FGB: begin
                case (idx)
                    4'd0, 4'd1, 4'd2, 4'd3: b = reset_byte(idx[1:0]);
                    4'd4:    b = CH_ESC;
                    4'd5:    b = CH_LBRACK;
                    4'd6:    b = CH_ONE;
                    4'd7:    b = CH_SEMI;
                    4'd8:    b = CH_THREE;
                    4'd9:    b = dch;
                    default: b = CH_M;
                endcase
            end
            K_BG: begin
                case (idx)
                    4'd0:    b = CH_ESC;
                    4'd1:    b = CH_LBRACK;
                    4'd2:    b = CH_FOUR;
                    4'd3:    b = dch;
                    default: b = CH_M;
                endcase
            end
            K_BGB: begin
                case (idx)
                    4'd0:    b = CH_ESC;
                    4'd1:    b = CH_LBRACK;
                    4'd2:    b = CH_ONE;
                    4'd3:    b = CH_ZERO;
                    4'd4:    b = dch;
                    default: b = CH_M;
                endcase
            end
            K_EOM: begin
                if (!has_pfx(cmd.pfx)) begin
                    b = reset_byte(idx[1:0]);
                end else if (idx == '0) begin
                    b = pfx_char(cmd.pfx);
                end else begin
                    b = reset_byte(j[1:0]);
                end
            end
            default: b = cmd.data;
        endcase
        return b;
    endfunction

endpackage

>>> design/color_markup_to_ansi_core.sv
// ----------------------------------------------------------------------------
// color_markup_to_ansi_core: color markup to ANSI escape translator
// Turns '&' / '^' two-character color markup into ANSI escape bytes.
// ----------------------------------------------------------------------------
// Each result byte passes through the output register, so plain text flows at
// one byte per cycle while the output is not stalled; a request makes
// no byte for a stored prefix, 1 byte for text, 2 for an
// unknown code, 4 for a reset, 5 or 6 for a background, 9 or 11 for a
// foreground, 4 or 5 at message end.
// The back end walks these bytes in order; the front end accepts the next
// request into a FIFO_DEPTH-entry command queue while a long sequence drains,
// and stalls intake only when that queue is full. Result bytes are loaded into
// the output register from the command at the head of the queue.
module color_markup_to_ansi_core #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_message,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_in_run,
    output logic       o_message_done
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    cmta_pkg::t_cmd q_in_cmd;
    cmta_pkg::t_cmd q_out_cmd;

    cmta_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_in_byte        (i_in_byte),
        .i_end_of_message (i_end_of_message),
        .i_q_full         (q_full),
        .o_q_push         (q_push),
        .o_q_cmd          (q_in_cmd)
    );

    cmta_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    cmta_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_cmd        (q_out_cmd),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_last_in_run  (o_last_in_run),
        .o_message_done (o_message_done)
    );

endmodule

>>> design/cmta_front.sv
// ----------------------------------------------------------------------------
// cmta_front: request intake and markup classification
// Tracks the pending color prefix and turns each request into one command for
// the back end, or none when a prefix byte is only stored.
// ----------------------------------------------------------------------------
module cmta_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_in_byte,
    input  logic            i_end_of_message,
    input  logic            i_q_full,
    output logic            o_q_push,
    output cmta_pkg::t_cmd  o_q_cmd
);

    cmta_pkg::t_pfx r_pending;
    cmta_pkg::t_pfx n_pending;
    cmta_pkg::t_cmd cmd;
    logic           enq;
    logic           is_color;
    logic           bright;
    logic [2:0]     digit;
    logic [7:0]     lc;

    // color letter decode; capitals select bright
    always_comb begin
        bright = (i_in_byte inside {[8'h41:8'h5A]});
        lc     = bright ? (i_in_byte + 8'd32) : i_in_byte;
        is_color = 1'b1;
        digit    = 3'd0;
        case (lc)
            8'h78:         digit = 3'd0;   // x
            8'h72:         digit = 3'd1;   // r
            8'h67:         digit = 3'd2;   // g
            8'h6F, 8'h79:  digit = 3'd3;   // o, y
            8'h62:         digit = 3'd4;   // b
            8'h70:         digit = 3'd5;   // p
            8'h63:         digit = 3'd6;   // c
            8'h77:         digit = 3'd7;   // w
            default:       is_color = 1'b0;
        endcase
    end

    always_comb begin
        cmd.kind  = cmta_pkg::K_TEXT;
        cmd.pfx   = r_pending;
        cmd.data  = i_in_byte;
        enq       = 1'b1;
        n_pending = cmta_pkg::PFX_NONE;
        if (i_end_of_message) begin
            cmd.kind = cmta_pkg::K_EOM;
        end else if (r_pending == cmta_pkg::PFX_AMP) begin
            if (is_color) begin
                cmd.kind = bright ? cmta_pkg::K_FGB : cmta_pkg::K_FG;
                cmd.data = {5'd0, digit};
            end else if (i_in_byte == cmta_pkg::CH_ZERO) begin
                cmd.kind = cmta_pkg::K_RST;
            end else begin
                cmd.kind = cmta_pkg::K_LIT;
            end
        end else if (r_pending == cmta_pkg::PFX_CARET) begin
            if (is_color) begin
                cmd.kind = bright ? cmta_pkg::K_BGB : cmta_pkg::K_BG;
                cmd.data = {5'd0, digit};
            end else begin
                cmd.kind = cmta_pkg::K_LIT;
            end
        end else if (i_in_byte == cmta_pkg::CH_AMP) begin
            enq       = 1'b0;
            n_pending = cmta_pkg::PFX_AMP;
        end else if (i_in_byte == cmta_pkg::CH_CARET) begin
            enq       = 1'b0;
            n_pending = cmta_pkg::PFX_CARET;
        end
    end

    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && o_in_ready && enq;
    assign o_q_cmd    = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= cmta_pkg::PFX_NONE;
        end else if (i_in_valid && o_in_ready) begin
            r_pending <= n_pending;
        end
    end

endmodule

>>> design/cmta_fifo.sv
// ----------------------------------------------------------------------------
// cmta_fifo: command queue between front end and back end
// Small register queue; lets intake continue while a long sequence drains.
// ----------------------------------------------------------------------------
module cmta_fifo #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cmta_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output cmta_pkg::t_cmd  o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmta_pkg::t_cmd  r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
        end
    end

endmodule

>>> design/cmta_back.sv
// ----------------------------------------------------------------------------
// cmta_back: sequence expansion and output register
// Walks the head command one byte per cycle unless stalled, onto the output.
// ----------------------------------------------------------------------------
module cmta_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  cmta_pkg::t_cmd  i_q_cmd,
    output logic            o_q_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last_in_run,
    output logic            o_message_done
);

    logic [cmta_pkg::IDX_W-1:0] r_idx;
    logic                       r_out_valid;
    logic [7:0]                 r_byte;
    logic                       r_last;
    logic                       r_done;
    logic                       load;
    logic                       last;

    assign load    = i_q_valid && (!r_out_valid || i_out_ready);
    assign last    = (r_idx == cmta_pkg::cmd_len(i_q_cmd) - cmta_pkg::IDX_W'(1));
    assign o_q_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= last ? '0 : r_idx + cmta_pkg::IDX_W'(1);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: hold while the output stalls
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= cmta_pkg::cmd_byte(i_q_cmd, r_idx);
            r_last <= last;
            r_done <= last && (i_q_cmd.kind == cmta_pkg::K_EOM);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_byte;
    assign o_last_in_run  = r_last;
    assign o_message_done = r_done;

endmodule
